[rtl/pressure_gauge_two_point_calibration_macros.svh]
// ----------------------------------------------------------------------------
// Pressure gauge assertion macros
// Shared concurrent assertion shorthands, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PRESSURE_GAUGE_TWO_POINT_CALIBRATION_MACROS_SVH
`define PRESSURE_GAUGE_TWO_POINT_CALIBRATION_MACROS_SVH

// Same-cycle implication
`define PGC_ASSERT_IMP(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("pgc assertion failed");

// Next-cycle implication
`define PGC_ASSERT_NXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("pgc assertion failed");

`endif

[rtl/pgc_pkg.sv]
// ----------------------------------------------------------------------------
// pgc_pkg
// Constants, types and helpers shared by the pressure gauge modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pgc_pkg;

  localparam int SAMPLES_PER_READING = 3;
  localparam int FULL_SCALE          = 600;
  localparam int LIMIT_TENTHS        = 10 * FULL_SCALE;
  localparam int CAL_K               = 1000 * (FULL_SCALE / 2) + 1;
  localparam int HALF_CODE           = 8388608;
  localparam int MV_BASE             = SAMPLES_PER_READING * HALF_CODE;
  localparam int LEVEL_STEP          = 1118481;
  localparam int FULL_MV             = 1280;

  localparam int SUM_W     = 27;
  localparam int DIFF_W    = 28;
  localparam int NUM_W     = 47;
  localparam int DEN_W     = 36;
  localparam int DIV_CNT_W = 6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MUL,
    S_START,
    S_DIV,
    S_WRITE
  } pgc_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic eval;
    logic mul;
    logic div_start;
    logic write;
  } pgc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic func;
    logic last;
    logic vmode;
    logic overload;
    logic div_busy;
    logic div_done;
    logic slot_free;
  } pgc_sts_t;

  // Display level: number of step thresholds at or below the code
  function automatic logic [3:0] level_of(input logic [23:0] raw);
    logic [3:0]  lvl;
    logic [24:0] thr;
    lvl = 4'd0;
    for (int k = 1; k < 16; k++) begin
      thr = 25'(k * LEVEL_STEP);
      if ({1'b0, raw} >= thr) begin
        lvl = lvl + 4'd1;
      end
    end
    return lvl;
  endfunction

endpackage

`default_nettype wire

[rtl/pgc_div.sv]
// ----------------------------------------------------------------------------
// pgc_div
// Sequential signed divider, one quotient bit per cycle, truncating toward 0.
// ----------------------------------------------------------------------------
`default_nettype none

module pgc_div
  import pgc_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [NUM_W-1:0] num,
  input  wire logic signed [DEN_W-1:0] den,
  output logic                         busy,
  output logic                         done,
  output logic             [NUM_W-1:0] quot_mag,
  output logic                         quot_neg
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0]     quot_r, quot_nxt;
  logic [DEN_W-1:0]     rem_r, rem_nxt;
  logic [DEN_W-1:0]     den_r, den_nxt;
  logic                 neg_r, neg_nxt;
  logic [DEN_W:0]       shifted;
  logic [DEN_W:0]       trial;

  assign shifted = {rem_r, quot_r[NUM_W-1]};
  assign trial   = shifted - {1'b0, den_r};

  // Load magnitudes on start, then shift and subtract once per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(NUM_W);
      quot_nxt = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      den_nxt  = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
      rem_nxt  = '0;
      neg_nxt  = num[NUM_W-1] ^ den[DEN_W-1];
    end else if (busy_r) begin
      if (!trial[DEN_W]) begin
        rem_nxt  = trial[DEN_W-1:0];
        quot_nxt = {quot_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt  = shifted[DEN_W-1:0];
        quot_nxt = {quot_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    neg_r  <= neg_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quot_mag = quot_r;
  assign quot_neg = neg_r;

endmodule

`default_nettype wire

[rtl/pgc_dp.sv]
// ----------------------------------------------------------------------------
// pgc_dp
// Datapath: sample accumulation, calibration points, scaling and result word.
// ----------------------------------------------------------------------------
`default_nettype none

module pgc_dp
  import pgc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire pgc_cmd_t    cmd,
  output pgc_sts_t         sts,
  input  wire logic        in_tuser,   // func
  input  wire logic [31:0] in_tdata,   // raw_sample[23:0], upper_button, lower_button
  input  wire logic        cfg_valid,
  input  wire logic        cfg_data,   // voltage_mode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic             out_tuser,  // kind
  output logic [31:0]      out_tdata   // tenths, millivolts, overload, blank, brightness
);

  localparam logic signed [19:0] K_S    = 20'(CAL_K);
  localparam logic signed [7:0]  HUND_S = 8'sd100;
  // ceil(2^17 / 3): exact floor division by 3 for operands below 2^16
  localparam logic [16:0]        DIV3_RECIP = 17'd43691;

  // Item and configuration registers
  logic                    func_r, up_r, lo_r;
  logic [23:0]             raw_r;
  logic                    vmode_r;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [1:0]              cnt_r, cnt_nxt;
  logic signed [SUM_W-1:0] upper_r, upper_nxt, lower_r, lower_nxt, reading_r;
  logic                    up_lat_r, up_lat_nxt, lo_lat_r, lo_lat_nxt;
  logic                    ovl_r, ovl_nxt, blink_r, blink_nxt;
  logic [3:0]              lvl_r, lvl_nxt;
  logic signed [NUM_W-1:0] num_r;
  logic signed [DEN_W-1:0] den_r;
  logic                    span_zero_r, diff_pos_r;
  logic                    oval_r, oval_nxt, ouser_r;
  logic [31:0]             odata_r;
  logic [11:0]             mv_r;

  logic signed [SUM_W-1:0]  term, sum_new;
  logic signed [DIFF_W-1:0] diff, span, vdiff;
  logic signed [47:0]       pprod;
  logic signed [DEN_W-1:0]  sprod;
  logic                     last;

  logic [26:0] vmag;
  logic [28:0] vx5;
  logic [30:0] vthird;
  logic [11:0] mv_mag;

  logic             div_busy, div_done, div_neg;
  logic [NUM_W-1:0] div_mag;

  logic        over;
  logic [12:0] tenths;
  logic [11:0] mv;
  logic        blink_new;
  logic        ouser_nxt;
  logic [31:0] odata_nxt;

  assign last = (cnt_r == 2'(SAMPLES_PER_READING - 1));

  // Offset removal follows the mode at sample time
  assign term    = vmode_r ? SUM_W'(signed'({1'b0, raw_r}))
                           : SUM_W'(signed'({1'b0, raw_r})) - SUM_W'(HALF_CODE);
  assign sum_new = sum_r + term;

  // Accumulate, capture calibration points, update display level
  always_comb begin
    sum_nxt    = sum_r;
    cnt_nxt    = cnt_r;
    upper_nxt  = upper_r;
    lower_nxt  = lower_r;
    up_lat_nxt = up_lat_r;
    lo_lat_nxt = lo_lat_r;
    lvl_nxt    = lvl_r;
    if (cmd.eval) begin
      if (func_r) begin
        lvl_nxt = level_of(raw_r);
      end else if (last) begin
        sum_nxt = '0;
        cnt_nxt = '0;
        if (!vmode_r) begin
          if (up_r && !up_lat_r) begin
            upper_nxt  = sum_new;
            up_lat_nxt = 1'b1;
          end
          if (lo_r && !lo_lat_r) begin
            lower_nxt  = sum_new;
            lo_lat_nxt = 1'b1;
          end
          if (!up_r) up_lat_nxt = 1'b0;
          if (!lo_r) lo_lat_nxt = 1'b0;
        end
      end else begin
        sum_nxt = sum_new;
        cnt_nxt = cnt_r + 2'd1;
      end
    end
  end

  // Scale numerator and denominator
  assign diff  = DIFF_W'(reading_r) - DIFF_W'(lower_r);
  assign span  = DIFF_W'(upper_r) - DIFF_W'(lower_r);
  assign vdiff = DIFF_W'(reading_r) - DIFF_W'(MV_BASE);
  assign pprod = diff * K_S;
  assign sprod = span * HUND_S;

  // Millivolts: diff * 1280 / (3 * 2^23) = diff * 5 / 2^15 / 3, on the magnitude
  assign vmag   = vdiff[DIFF_W-1] ? 27'(-vdiff) : 27'(vdiff);
  assign vx5    = {vmag, 2'b00} + {2'b00, vmag};
  assign vthird = 31'(vx5[28:15]) * 31'(DIV3_RECIP);
  assign mv_mag = vthird[28:17];
  assign mv     = vdiff[DIFF_W-1] ? (~mv_mag + 12'd1) : mv_mag;

  pgc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .num      (num_r),
    .den      (den_r),
    .busy     (div_busy),
    .done     (div_done),
    .quot_mag (div_mag),
    .quot_neg (div_neg)
  );

  // Clamp the calibrated value and flag overload
  always_comb begin
    if (span_zero_r) begin
      over   = diff_pos_r;
      tenths = diff_pos_r ? 13'(LIMIT_TENTHS) : 13'd0;
    end else if (div_neg) begin
      over   = 1'b0;
      tenths = 13'd0;
    end else begin
      over   = (div_mag >= NUM_W'(LIMIT_TENTHS));
      tenths = over ? 13'(LIMIT_TENTHS) : div_mag[12:0];
    end
  end

  assign blink_new = over ? ~blink_r : 1'b1;

  // Form the result word
  always_comb begin
    ovl_nxt   = ovl_r;
    blink_nxt = blink_r;
    ouser_nxt = 1'b0;
    odata_nxt = {1'b0, lvl_r, 1'b0, 1'b0, 12'd0, 13'd0};
    if (!func_r) begin
      ouser_nxt = 1'b1;
      if (vmode_r) begin
        odata_nxt = {1'b0, lvl_r, 1'b0, 1'b0, mv_r, 13'd0};
      end else begin
        ovl_nxt   = over;
        blink_nxt = blink_new;
        odata_nxt = {1'b0, over ? 4'hF : lvl_r, over & blink_new, over, 12'd0, tenths};
      end
    end
    if (!cmd.write) begin
      ovl_nxt   = ovl_r;
      blink_nxt = blink_r;
    end
  end

  assign oval_nxt = cmd.write ? 1'b1 : (oval_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vmode_r  <= 1'b0;
      sum_r    <= '0;
      cnt_r    <= '0;
      upper_r  <= SUM_W'(1);
      lower_r  <= '0;
      up_lat_r <= 1'b0;
      lo_lat_r <= 1'b0;
      ovl_r    <= 1'b0;
      blink_r  <= 1'b1;
      lvl_r    <= '0;
      oval_r   <= 1'b0;
    end else begin
      if (cfg_valid) vmode_r <= cfg_data;
      sum_r    <= sum_nxt;
      cnt_r    <= cnt_nxt;
      upper_r  <= upper_nxt;
      lower_r  <= lower_nxt;
      up_lat_r <= up_lat_nxt;
      lo_lat_r <= lo_lat_nxt;
      ovl_r    <= ovl_nxt;
      blink_r  <= blink_nxt;
      lvl_r    <= lvl_nxt;
      oval_r   <= oval_nxt;
    end
    // Payload registers
    if (cmd.load) begin
      func_r <= in_tuser;
      raw_r  <= in_tdata[23:0];
      up_r   <= in_tdata[24];
      lo_r   <= in_tdata[25];
    end
    if (cmd.eval && !func_r && last) reading_r <= sum_new;
    if (cmd.mul) begin
      num_r       <= pprod[NUM_W-1:0];
      den_r       <= sprod;
      mv_r        <= mv;
      span_zero_r <= (span == '0);
      diff_pos_r  <= (diff > 28'sd0);
    end
    if (cmd.write) begin
      ouser_r <= ouser_nxt;
      odata_r <= odata_nxt;
    end
  end

  assign sts.func      = func_r;
  assign sts.last      = last;
  assign sts.vmode     = vmode_r;
  assign sts.overload  = ovl_r;
  assign sts.div_busy  = div_busy;
  assign sts.div_done  = div_done;
  assign sts.slot_free = !oval_r || out_tready;

  assign out_tvalid = oval_r;
  assign out_tuser  = ouser_r;
  assign out_tdata  = odata_r;

endmodule

`default_nettype wire

[rtl/pgc_ctrl.sv]
// ----------------------------------------------------------------------------
// pgc_ctrl
// Controller: sequences evaluate, scale, divide and result write per word.
// ----------------------------------------------------------------------------
`default_nettype none

module pgc_ctrl
  import pgc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  input  wire pgc_sts_t sts,
  output pgc_cmd_t      cmd
);

`include "pressure_gauge_two_point_calibration_macros.svh"

  pgc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (sts.func) begin
          state_nxt = sts.overload ? S_IDLE : S_WRITE;
        end else begin
          state_nxt = sts.last ? S_MUL : S_IDLE;
        end
      end
      S_MUL: begin
        // Voltage readings need no divider
        cmd.mul   = 1'b1;
        state_nxt = sts.vmode ? S_WRITE : S_START;
      end
      S_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_WRITE;
      end
      S_WRITE: begin
        if (sts.slot_free) begin
          cmd.write = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `PGC_ASSERT_IMP(a_div_only_waiting, sts.div_done, state_r == S_DIV)
  `PGC_ASSERT_IMP(a_div_running, state_r == S_DIV, sts.div_busy || sts.div_done)
  `PGC_ASSERT_NXT(a_bright_result, state_r == S_EVAL && sts.func && !sts.overload,
                  state_r == S_WRITE)
  `PGC_ASSERT_IMP(a_write_has_slot, cmd.write, sts.slot_free)

endmodule

`default_nettype wire

[rtl/pressure_gauge_two_point_calibration.sv]
// ----------------------------------------------------------------------------
// pressure_gauge_two_point_calibration
// Two-point calibrated pressure gauge with brightness control, top level.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per converter sample; in_tuser is the channel (0
//           pressure, 1 brightness), in_tdata carries the code and buttons.
//   out_* : result words; out_tuser is the kind (0 brightness, 1 reading).
//   cfg_* : voltage_mode write, taken every cycle; write only while idle.
// Throughput: one word at a time. Non-final pressure words and brightness
//   words during overload pass evaluate only; other brightness words pass
//   evaluate and write; final voltage words pass evaluate, scale and write;
//   final pressure words pass evaluate, scale, start, the 47-step
//   shift-subtract divider and write.
// Reset (rst_n low, synchronous): calibration points become 1 and 0, sums,
//   latches, overload and level clear, blink phase is set, mode is pressure.
// Stall: a result waits in the output register while out_tready is low;
//   inputs keep flowing until the next result is ready to be written.
// ----------------------------------------------------------------------------
`default_nettype none

module pressure_gauge_two_point_calibration
  import pgc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic        in_tuser,   // func
  input  wire logic [31:0] in_tdata,   // raw_sample[23:0], upper_button, lower_button
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic             out_tuser,  // kind
  output logic [31:0]      out_tdata,  // pressure_tenths[12:0], millivolts[24:13],
                                       // overload, blank, brightness[30:27]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data    // voltage_mode
);

  pgc_cmd_t cmd;
  pgc_sts_t sts;

  assign cfg_ready = 1'b1;

  pgc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pgc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

[tb/pressure_gauge_two_point_calibration_checker.sv]
// ----------------------------------------------------------------------------
// Pressure gauge result checker
// Watches the sample, result and mode channels, predicts every result word
// of the two-point calibration gauge and compares it, reporting a mismatch field by field.
// ----------------------------------------------------------------------------
module pressure_gauge_two_point_calibration_checker
  import pgc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic        in_tuser,
  input  logic [31:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic        out_tuser,
  input  logic [31:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_data,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        kind;
    logic [31:0] data;
  } reading_t;

  reading_t readings_due[$];

  // gauge state mirror
  logic            volt_mode;
  longint          acc_sum;
  int              acc_count;
  longint          cal_hi, cal_lo;
  logic            hi_held, lo_held, over_on, blink;
  logic [3:0]      level;

  assign pending = readings_due.size();

  function automatic logic [31:0] pack_word(logic [12:0] tenths, logic [11:0] mv,
                                            logic ovl, logic blk, logic [3:0] bri);
    return {1'b0, bri, blk, ovl, mv, tenths};
  endfunction

  // advance the mirror by one accepted sample word
  task automatic take_sample(logic func, logic [31:0] word);
    logic [23:0] raw;
    longint      sum, span, diff, q, mv, base;
    raw = word[23:0];
    if (func) begin
      level = 4'(raw / LEVEL_STEP);
      if (!over_on) readings_due.push_back({1'b0, pack_word(0, 0, 0, 0, level)});
      return;
    end
    acc_sum += volt_mode ? longint'(raw) : longint'(raw) - HALF_CODE;
    acc_count++;
    if (acc_count < SAMPLES_PER_READING) return;
    sum = acc_sum;
    acc_sum = 0;
    acc_count = 0;
    if (volt_mode) begin
      base = longint'(SAMPLES_PER_READING) * HALF_CODE;
      mv = ((sum - base) * FULL_MV) / base;
      readings_due.push_back({1'b1, pack_word(0, 12'(mv), 0, 0, level)});
      return;
    end
    if (word[24] && !hi_held) begin cal_hi = sum; hi_held = 1; end
    if (word[25] && !lo_held) begin cal_lo = sum; lo_held = 1; end
    if (!word[24]) hi_held = 0;
    if (!word[25]) lo_held = 0;
    span = cal_hi - cal_lo;
    diff = sum - cal_lo;
    if (span == 0) q = diff > 0 ? LIMIT_TENTHS : 0;
    else begin
      q = (diff * CAL_K) / (span * 100);
      if (q < 0) q = 0;
    end
    if (q >= LIMIT_TENTHS) begin
      q = LIMIT_TENTHS;
      over_on = 1;
      blink = !blink;
    end else begin
      over_on = 0;
      blink = 1;
    end
    readings_due.push_back({1'b1, pack_word(13'(q), 0, over_on, over_on & blink,
                                            over_on ? 4'hF : level)});
  endtask

  always @(posedge clk) begin
    reading_t want;
    if (!rst_n) begin
      volt_mode <= 0;
      acc_sum = 0; acc_count = 0; cal_hi = 1; cal_lo = 0;
      hi_held = 0; lo_held = 0; over_on = 0; blink = 1; level = 0;
      readings_due.delete();
      errors <= 0;
    end else begin
      // check the result word first: it cannot depend on this cycle's sample
      if (out_tvalid && out_tready) begin
        if (readings_due.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual kind %0d data %h",
                   $time, out_tuser, out_tdata);
          errors <= errors + 1;
        end else begin
          want = readings_due.pop_front();
          if (want.kind !== out_tuser || want.data !== out_tdata) begin
            $display("%0t: mismatch: expected kind %0d tenths %0d mv %0d ovl %0d blank %0d bri %0d, actual kind %0d tenths %0d mv %0d ovl %0d blank %0d bri %0d",
                     $time, want.kind, want.data[12:0], $signed(want.data[24:13]),
                     want.data[25], want.data[26], want.data[30:27],
                     out_tuser, out_tdata[12:0], $signed(out_tdata[24:13]),
                     out_tdata[25], out_tdata[26], out_tdata[30:27]);
            errors <= errors + 1;
          end
        end
      end
      if (in_tvalid && in_tready) take_sample(in_tuser, in_tdata);
      if (cfg_valid && cfg_ready) volt_mode <= cfg_data;
    end
  end
endmodule

[tb/pressure_gauge_two_point_calibration_test.sv]
// ----------------------------------------------------------------------------
// Pressure gauge calibration testbench
// Drives directed and random sample words through both gauge modes with
// random idling on both channels and a long output hold-off; the checker
// predicts and compares each result word.
// ----------------------------------------------------------------------------
module pressure_gauge_two_point_calibration_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int RANDOM_WORDS = 1830;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0, in_tuser = 0;
  logic [31:0] in_tdata = 0;
  logic        out_tready = 0;
  logic        cfg_valid = 0, cfg_data = 0;
  wire         in_tready, out_tvalid, out_tuser, cfg_ready;
  wire  [31:0] out_tdata;
  int          errors, pending;
  int          cycles = 0;
  bit          calm = 0;       // no idling near the end
  bit          hold_off = 0;   // long output stall request

  pressure_gauge_two_point_calibration uut (.*);
  pressure_gauge_two_point_calibration_checker watch (.*);

  initial forever #10 clk = ~clk;

  // guard against a hung block
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // output side: random stall bursts, plus one long hold-off
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_tready <= 0;
        repeat (600) @(posedge clk);
        hold_off = 0;
      end
      if (!calm && $urandom_range(3) == 0) begin
        out_tready <= 0;
        n = $urandom_range(16, 1);
        repeat (n) @(posedge clk);
      end
      out_tready <= 1;
    end
  end

  // offer one sample word and wait for it to be taken
  task automatic send_word(logic func, logic [23:0] raw, logic up, logic lo);
    int n;
    if (!calm && $urandom_range(4) == 0) begin
      in_tvalid <= 0;
      n = $urandom_range(16, 1);
      repeat (n) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= func;
    in_tdata <= {6'b0, lo, up, raw};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // one reading: three pressure words, buttons on the last one
  task automatic send_reading(logic [23:0] a, logic [23:0] b, logic [23:0] c,
                              logic up, logic lo);
    send_word(0, a, 0, 0);
    send_word(0, b, 0, 0);
    send_word(0, c, up, lo);
  endtask

  // drain and switch the mode register
  task automatic set_mode(logic mode);
    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  function automatic logic [23:0] near(logic [23:0] c);
    return c + 24'($urandom_range(4000)) - 24'd2000;
  endfunction

  initial begin
    logic [23:0] lo_c, hi_c, c;
    int r;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: brightness extremes, calibration, equal points, overload, mV
    send_word(1, 24'h000000, 0, 0);
    send_word(1, 24'hFFFFFF, 1, 1);
    send_word(1, 24'd1118481, 0, 0);
    send_reading(24'h800000, 24'h800000, 24'h800000, 0, 0);
    send_reading(24'h800000, 24'h800000, 24'h800000, 1, 1);   // equal points
    send_reading(24'h800001, 24'h800000, 24'h800000, 0, 0);   // above the point
    send_word(1, 24'h777777, 0, 0);                             // held off by overload
    send_reading(24'h700000, 24'h700000, 24'h700000, 0, 1);   // lower point
    send_reading(24'h900000, 24'h900000, 24'h900000, 1, 0);   // upper point
    send_reading(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0, 0);   // clamp
    send_reading(24'h000000, 24'h000000, 24'h000000, 0, 0);   // below zero
    set_mode(1);
    send_reading(24'h000000, 24'h000000, 24'h000000, 1, 1);
    send_reading(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0, 0);
    send_word(1, 24'h123456, 0, 0);
    set_mode(0);

    // random: mostly readings around two calibration points
    for (int ph = 0; ph < 6; ph++) begin
      lo_c = 24'($urandom_range(24'hC00000, 24'h100000));
      hi_c = 24'($urandom_range(24'hFFFFFF, 24'h000000));
      send_reading(lo_c, lo_c, lo_c, 0, 1);
      send_reading(hi_c, hi_c, hi_c, 1, 0);
      if (ph == 2) hold_off = 1;
      if (ph == 5) calm = 1;
      for (int i = 0; i < RANDOM_WORDS / 6; i++) begin
        r = $urandom_range(9);
        if (r < 2) send_word(1, 24'($urandom), 1'($urandom_range(1)),
                             1'($urandom_range(1)));
        else begin
          c = (r < 7) ? near($urandom_range(1) ? lo_c : hi_c) : 24'($urandom);
          send_word(0, c, $urandom_range(7) == 0, $urandom_range(7) == 0);
        end
      end
      if (ph == 1 || ph == 3) set_mode(1);
      else set_mode(0);
    end

    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
